/* sv/eom_pkg.sv */
package eom_pkg;
	localparam int MaxExtentsDefault = 16;
	localparam int QueueDepth = 2;

	typedef enum logic [1:0] {
		PIECE_NEW   = 2'd0,
		PIECE_AVAIL = 2'd1,
		PIECE_FULL  = 2'd2
	} piece_kind_t;

	typedef enum logic {
		CMD_ADD   = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] device;
		logic [63:0] phys_start;
		logic [63:0] logical_start;
		logic [63:0] extent_length;
		logic [31:0] file_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  piece_kind;
		logic [63:0] piece_logical;
		logic [63:0] piece_length;
		logic [31:0] source_file;
		logic [63:0] source_logical;
		logic        last_piece;
	} out_item_t;

	typedef struct packed {
		logic        clear;
		logic [31:0] device;
		logic [63:0] phys;
		logic [63:0] logical;
		logic [63:0] length;
		logic [31:0] file;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LO,
		ST_HI,
		ST_BS,
		ST_WALK,
		ST_GAP,
		ST_COVER,
		ST_TAIL,
		ST_SHIFT,
		ST_PUT,
		ST_EMIT
	} state_t;
endpackage

/* sv/eom_in_if.sv */
interface eom_in_if;
	logic              valid;
	logic              ready;
	eom_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* sv/eom_out_if.sv */
interface eom_out_if;
	logic               valid;
	logic               ready;
	eom_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* sv/eom_front.sv */
module eom_front (
	input  logic              clk,
	input  logic              arst_n,
	eom_in_if.sink            in_ch,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output eom_pkg::cmd_t     cmd
);
	localparam int AW = $clog2(eom_pkg::QueueDepth);

	eom_pkg::cmd_t          fifo_q [eom_pkg::QueueDepth];
	logic [AW-1:0]          wr_q;
	logic [AW-1:0]          rd_q;
	logic [AW:0]            cnt_q;
	logic                   push;
	logic                   pop;
	logic                   drop;

	// Zero-length adds do nothing and are dropped here.
	assign drop = (in_ch.data.kind == eom_pkg::CMD_ADD) && (in_ch.data.extent_length == '0);
	assign in_ch.ready = (cnt_q != (AW+1)'(eom_pkg::QueueDepth));
	assign push = in_ch.valid && in_ch.ready && !drop;
	assign pop = cmd_valid && cmd_ready;
	assign cmd_valid = (cnt_q != '0);
	assign cmd = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(eom_pkg::QueueDepth-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(eom_pkg::QueueDepth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q].clear <= in_ch.data.kind;
			fifo_q[wr_q].device <= in_ch.data.device;
			fifo_q[wr_q].phys <= in_ch.data.phys_start;
			fifo_q[wr_q].logical <= in_ch.data.logical_start;
			fifo_q[wr_q].length <= in_ch.data.extent_length;
			fifo_q[wr_q].file <= in_ch.data.file_id;
		end
	end
endmodule

/* sv/eom_back.sv */
module eom_back #(
	parameter int MAX_EXTENTS = eom_pkg::MaxExtentsDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  eom_pkg::cmd_t cmd,
	eom_out_if.source     out_ch
);
	localparam int IW = $clog2(MAX_EXTENTS + 1);
	localparam int AW = $clog2(MAX_EXTENTS);

	logic [31:0] dev_mem [MAX_EXTENTS];
	logic [63:0] phys_mem [MAX_EXTENTS];
	logic [63:0] log_mem [MAX_EXTENTS];
	logic [63:0] len_mem [MAX_EXTENTS];
	logic [31:0] file_mem [MAX_EXTENTS];

	eom_pkg::state_t state_q, state_d;
	logic [IW-1:0] count_q, count_d;
	logic [IW-1:0] lo_q, lo_d, hi_q, hi_d, a_q, a_d, b_q, b_d, idx_q, idx_d, sh_q, sh_d;
	logic [31:0]   dev_q, dev_d, file_q, file_d;
	logic [63:0]   ph_q, ph_d, lg_q, lg_d, len_q, len_d;
	logic          stop_q, stop_d;

	// Registered entry read port.
	logic [IW-1:0] rd_addr;
	logic [31:0]   e_dev_q, e_file_q;
	logic [63:0]   e_ph_q, e_log_q, e_len_q;
	logic          rd_pend_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   w_dev, w_file;
	logic [63:0]   w_ph, w_log, w_len;
	logic          sh_en;

	eom_pkg::out_item_t obuf_q, obuf_d;
	logic               ovalid_q, ovalid_d;

	logic [IW-1:0] mid;
	logic [64:0]   e_end, n_end, pos65;

	assign out_ch.valid = ovalid_q;
	assign out_ch.data = obuf_q;
	assign cmd_ready = (state_q == eom_pkg::ST_IDLE);
	assign mid = a_q + ((b_q - a_q) >> 1);
	assign e_end = {1'b0, e_ph_q} + {1'b0, e_len_q};
	assign n_end = {1'b0, ph_q} + {1'b0, len_q};
	assign pos65 = {1'b0, ph_q};

	always_ff @(posedge clk) begin
		e_dev_q <= dev_mem[rd_addr[AW-1:0]];
		e_ph_q <= phys_mem[rd_addr[AW-1:0]];
		e_log_q <= log_mem[rd_addr[AW-1:0]];
		e_len_q <= len_mem[rd_addr[AW-1:0]];
		e_file_q <= file_mem[rd_addr[AW-1:0]];
		if (sh_en) begin
			dev_mem[sh_q[AW-1:0]] <= e_dev_q;
			phys_mem[sh_q[AW-1:0]] <= e_ph_q;
			log_mem[sh_q[AW-1:0]] <= e_log_q;
			len_mem[sh_q[AW-1:0]] <= e_len_q;
			file_mem[sh_q[AW-1:0]] <= e_file_q;
		end else if (wr_en) begin
			dev_mem[wr_addr] <= w_dev;
			phys_mem[wr_addr] <= w_ph;
			log_mem[wr_addr] <= w_log;
			len_mem[wr_addr] <= w_len;
			file_mem[wr_addr] <= w_file;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eom_pkg::ST_IDLE;
			count_q <= '0;
			ovalid_q <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ovalid_q <= ovalid_d;
			rd_pend_q <= (state_d != state_q) || (idx_d != idx_q) || sh_en;
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= lo_d; hi_q <= hi_d; a_q <= a_d; b_q <= b_d; idx_q <= idx_d; sh_q <= sh_d;
		dev_q <= dev_d; file_q <= file_d; ph_q <= ph_d; lg_q <= lg_d; len_q <= len_d;
		stop_q <= stop_d;
		obuf_q <= obuf_d;
	end

	always_comb begin
		state_d = state_q; count_d = count_q;
		lo_d = lo_q; hi_d = hi_q; a_d = a_q; b_d = b_q; idx_d = idx_q; sh_d = sh_q;
		dev_d = dev_q; file_d = file_q; ph_d = ph_q; lg_d = lg_q; len_d = len_q;
		stop_d = stop_q;
		obuf_d = obuf_q;
		ovalid_d = ovalid_q && !out_ch.ready;
		rd_addr = idx_q;
		wr_en = 1'b0; sh_en = 1'b0;
		wr_addr = idx_q[AW-1:0];
		w_dev = dev_q; w_ph = ph_q; w_log = lg_q; w_len = len_q; w_file = file_q;
		case (state_q)
			eom_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.clear) begin
						count_d = '0;
					end else begin
						dev_d = cmd.device; file_d = cmd.file; ph_d = cmd.phys;
						lg_d = cmd.logical; len_d = cmd.length;
						idx_d = '0;
						state_d = eom_pkg::ST_LO;
					end
				end
			end
			// Each read waits, via rd_pend_q, for the address to settle into the read register.
			eom_pkg::ST_LO: begin
				if (!rd_pend_q) begin
					if (idx_q < count_q && e_dev_q < dev_q) begin
						idx_d = idx_q + 1'b1;
					end else begin
						lo_d = idx_q;
						state_d = eom_pkg::ST_HI;
					end
				end
			end
			eom_pkg::ST_HI: begin
				if (!rd_pend_q) begin
					if (idx_q < count_q && e_dev_q == dev_q) begin
						idx_d = idx_q + 1'b1;
					end else begin
						hi_d = idx_q;
						a_d = lo_q; b_d = idx_q;
						idx_d = lo_q + ((idx_q - lo_q) >> 1);
						state_d = eom_pkg::ST_BS;
					end
				end
			end
			eom_pkg::ST_BS: begin
				if (a_q == b_q) begin
					idx_d = a_q;
					state_d = eom_pkg::ST_WALK;
				end else if (!rd_pend_q) begin
					if (ph_q < e_ph_q) begin
						b_d = mid;
						idx_d = a_q + ((mid - a_q) >> 1);
					end else if (e_end <= pos65) begin
						a_d = mid + 1'b1;
						idx_d = mid + 1'b1 + ((b_q - mid - 1'b1) >> 1);
					end else begin
						idx_d = mid;
						state_d = eom_pkg::ST_WALK;
					end
				end
			end
			eom_pkg::ST_WALK: begin
				if (idx_q == hi_q) begin
					state_d = eom_pkg::ST_TAIL;
				end else if (!rd_pend_q) begin
					if (n_end <= {1'b0, e_ph_q}) begin
						state_d = eom_pkg::ST_TAIL;
					end else if (ph_q < e_ph_q) begin
						state_d = eom_pkg::ST_GAP;
					end else begin
						state_d = eom_pkg::ST_COVER;
					end
				end
			end
			eom_pkg::ST_GAP: begin
				if (!ovalid_d) begin
					obuf_d.piece_logical = lg_q;
					obuf_d.piece_length = e_ph_q - ph_q;
					obuf_d.source_file = '0;
					obuf_d.source_logical = '0;
					ovalid_d = 1'b1;
					if (count_q >= IW'(MAX_EXTENTS)) begin
						obuf_d.piece_kind = eom_pkg::PIECE_FULL;
						obuf_d.last_piece = 1'b1;
						state_d = eom_pkg::ST_IDLE;
					end else begin
						obuf_d.piece_kind = eom_pkg::PIECE_NEW;
						obuf_d.last_piece = 1'b0;
						w_len = e_ph_q - ph_q;
						len_d = len_q - (e_ph_q - ph_q);
						stop_d = 1'b0;
						sh_d = count_q;
						state_d = eom_pkg::ST_SHIFT;
					end
				end
			end
			eom_pkg::ST_COVER: begin
				if (!ovalid_d) begin
					obuf_d.piece_kind = eom_pkg::PIECE_AVAIL;
					obuf_d.piece_logical = lg_q;
					obuf_d.source_file = e_file_q;
					obuf_d.source_logical = e_log_q + (ph_q - e_ph_q);
					ovalid_d = 1'b1;
					if (e_end >= n_end) begin
						obuf_d.piece_length = len_q;
						obuf_d.last_piece = 1'b1;
						state_d = eom_pkg::ST_IDLE;
					end else begin
						obuf_d.piece_length = e_end[63:0] - ph_q;
						obuf_d.last_piece = 1'b0;
						ph_d = e_end[63:0];
						lg_d = lg_q + (e_end[63:0] - ph_q);
						len_d = len_q - (e_end[63:0] - ph_q);
						idx_d = idx_q + 1'b1;
						state_d = eom_pkg::ST_WALK;
					end
				end
			end
			eom_pkg::ST_TAIL: begin
				if (!ovalid_d) begin
					obuf_d.piece_logical = lg_q;
					obuf_d.piece_length = len_q;
					obuf_d.source_file = '0;
					obuf_d.source_logical = '0;
					obuf_d.last_piece = 1'b1;
					ovalid_d = 1'b1;
					if (count_q >= IW'(MAX_EXTENTS)) begin
						obuf_d.piece_kind = eom_pkg::PIECE_FULL;
						state_d = eom_pkg::ST_IDLE;
					end else begin
						obuf_d.piece_kind = eom_pkg::PIECE_NEW;
						stop_d = 1'b1;
						sh_d = count_q;
						state_d = eom_pkg::ST_SHIFT;
					end
				end
			end
			// Move entries up one place from the top down to idx, then write the new entry at idx.
			eom_pkg::ST_SHIFT: begin
				rd_addr = sh_q - 1'b1;
				if (sh_q == idx_q) begin
					state_d = eom_pkg::ST_PUT;
				end else if (!rd_pend_q) begin
					sh_en = 1'b1;
					sh_d = sh_q - 1'b1;
				end
			end
			eom_pkg::ST_PUT: begin
				wr_en = 1'b1;
				if (!stop_q) w_len = obuf_q.piece_length;
				count_d = count_q + 1'b1;
				if (stop_q) begin
					state_d = eom_pkg::ST_IDLE;
				end else begin
					ph_d = ph_q + obuf_q.piece_length;
					lg_d = lg_q + obuf_q.piece_length;
					hi_d = hi_q + 1'b1;
					idx_d = idx_q + 1'b1;
					state_d = eom_pkg::ST_COVER;
					rd_addr = idx_q + 1'b1;
					state_d = eom_pkg::ST_EMIT;
				end
			end
			eom_pkg::ST_EMIT: begin
				if (!rd_pend_q) state_d = eom_pkg::ST_COVER;
			end
			default: state_d = eom_pkg::ST_IDLE;
		endcase
	end
endmodule

/* sv/extent_overlap_map_core.sv */
// Operation: an add walks the table to find the device range, binary searches that range,
// then emits its result pieces one at a time, shifting entries up on each insert; output
// stalls hold the engine.
// Flow: the table engine takes one item at a time and accepts no new item until an add is
// done; a clear item empties the table. A two-entry queue sits in front of the engine.
// Reset: arst_n empties the table and the queue; stored entries are not cleared.
module extent_overlap_map_core #(
	parameter int MAX_EXTENTS = eom_pkg::MaxExtentsDefault
) (
	input logic       clk,
	input logic       arst_n,
	eom_in_if.sink    in_ch,
	eom_out_if.source out_ch
);
	logic          cmd_valid;
	logic          cmd_ready;
	eom_pkg::cmd_t cmd;

	eom_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	eom_back #(.MAX_EXTENTS(MAX_EXTENTS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.out_ch(out_ch)
	);
endmodule

/* sv/eom_checker.sv */
module eom_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] out_kind,
	input logic out_last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind == eom_pkg::PIECE_NEW || out_kind == eom_pkg::PIECE_AVAIL
		|| out_kind == eom_pkg::PIECE_FULL)) else $error("bad kind");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == eom_pkg::PIECE_FULL |-> out_last) else $error("full not last");
endmodule

bind extent_overlap_map_core eom_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_kind(out_ch.data.piece_kind), .out_last(out_ch.data.last_piece)
);
